// File: hdl/dacs_pkg.sv
// Shared types and constants for the chunk encoder.
// Holds table entry layout, register indexes, reset values and FSM codes.
`default_nettype none

package dacs_pkg;

    localparam int MAX_LEVELS  = 32;
    localparam int VALUE_BITS  = 32;
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    localparam int CW_W        = 6;
    localparam int BASE_W      = VALUE_BITS + 1;
    localparam int LIST_LEN    = 8;
    localparam int LIST_IDX_W  = $clog2(LIST_LEN);
    localparam int LIST_W      = LIST_LEN * CW_W;
    localparam int LCNT_W      = 4;
    localparam int LVCNT_W     = LVL_W + 1;
    localparam int CFG_DATA_W  = LIST_W;
    localparam int CFG_ADDR_W  = 2;
    localparam int S_TDATA_W   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W  = LVL_W + VALUE_BITS + CW_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 3;

    localparam logic [CW_W-1:0]    MAX_CW     = CW_W'(VALUE_BITS);
    localparam logic [BASE_W-1:0]  BASE_CAP   = BASE_W'(1) << VALUE_BITS;

    localparam logic [LIST_W-1:0]  RESET_WIDTHS     = 48'd17871427092740;
    localparam logic [LCNT_W-1:0]  RESET_LIST_COUNT = 4'd8;
    localparam logic [LVCNT_W-1:0] RESET_LEVELS     = 6'd8;

    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH_LIST  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIST_COUNT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_COUNT = 2'd2;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [CW_W-1:0]   width;
    } lvl_entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_EMIT   = 4'b1000
    } enc_state_t;

endpackage

`default_nettype wire

// File: hdl/dacs_chunk_encoder.sv
// Per-level throughput: one probe of the level table per cycle, and one chunk per cycle
// while the output register is free (m_tready high or m_tvalid low). An item of top level j
// is probed from level 1 up to a miss or the last level in use, then gives j + 1 chunks.
// The level table is a single-port-read memory: each probe and each chunk is one read.
// Reset (aresetn low, synchronous) and every config write start a rebuild of all 32 table
// entries, one entry per cycle; s_tready stays low until it completes.
`default_nettype none

module dacs_chunk_encoder
    import dacs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] value

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [4:0] level, [36:5] chunk, [42:37] chunk_width
    output logic [M_TUSER_W-1:0]       m_tuser,   // [0] stop, [1] in_bitmap, [2] overflow
    output logic                       m_tlast
);

    // configuration
    logic [LIST_W-1:0]  width_list_reg;
    logic [LCNT_W-1:0]  list_count_reg;
    logic [LVCNT_W-1:0] level_count_reg;

    // level table
    lvl_entry_t         lvl_mem [MAX_LEVELS];
    lvl_entry_t         rd_data_reg;
    logic [LVL_W-1:0]   rd_addr;
    logic               wr_en;
    lvl_entry_t         wr_data;

    // rebuild
    logic [LVL_W-1:0]   reb_idx_reg, reb_idx_next;
    logic [CW_W-1:0]    reb_exp_reg, reb_exp_next;
    logic [BASE_W-1:0]  reb_base_reg, reb_base_next;

    // item control
    enc_state_t         state_reg, state_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [LVL_W-1:0]   probe_reg, probe_next;
    logic [LVL_W-1:0]   top_reg, top_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg, m_user_next;
    logic               m_last_reg, m_last_next;

    // derived
    logic [LVCNT_W-1:0] levels;
    logic [LCNT_W-1:0]  list_n;
    logic [LIST_IDX_W-1:0] fld_idx;
    logic [CW_W-1:0]    fld_raw, fld_w;
    logic [CW_W:0]      exp_sum;
    logic [CW_W-1:0]    exp_sat;
    logic [BASE_W:0]    base_sum;
    logic               accept;
    logic               hit;
    logic               probe_more;
    logic               out_free;
    logic               fin;
    logic [CW_W-1:0]    cur_w;
    logic [VALUE_BITS-1:0] chunk_mask, chunk_val, rem_shift;
    logic               in_bitmap;
    logic               ovf;

    // ---------------- configuration registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_list_reg  <= RESET_WIDTHS;
            list_count_reg  <= RESET_LIST_COUNT;
            level_count_reg <= RESET_LEVELS;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_WIDTH_LIST:  width_list_reg  <= cfg_wdata;
                CFG_LIST_COUNT:  list_count_reg  <= cfg_wdata[LCNT_W-1:0];
                CFG_LEVEL_COUNT: level_count_reg <= cfg_wdata[LVCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (level_count_reg == '0)
            levels = LVCNT_W'(1);
        else if (level_count_reg > LVCNT_W'(MAX_LEVELS))
            levels = LVCNT_W'(MAX_LEVELS);
        else
            levels = level_count_reg;

        if (list_count_reg == '0)
            list_n = LCNT_W'(1);
        else if (list_count_reg > LCNT_W'(LIST_LEN))
            list_n = LCNT_W'(LIST_LEN);
        else
            list_n = list_count_reg;
    end

    // ---------------- table rebuild ----------------
    always_comb begin
        if ({{(LVL_W+1-LCNT_W){1'b0}}, list_n} > {1'b0, reb_idx_reg})
            fld_idx = reb_idx_reg[LIST_IDX_W-1:0];
        else
            fld_idx = LIST_IDX_W'(list_n - LCNT_W'(1));

        fld_raw = width_list_reg[fld_idx * CW_W +: CW_W];
        if (fld_raw == '0)
            fld_w = CW_W'(1);
        else if (fld_raw > MAX_CW)
            fld_w = MAX_CW;
        else
            fld_w = fld_raw;

        exp_sum = {1'b0, reb_exp_reg} + {1'b0, fld_w};
        exp_sat = (exp_sum > {1'b0, MAX_CW}) ? MAX_CW : exp_sum[CW_W-1:0];

        base_sum = {1'b0, reb_base_reg} + ((BASE_W+1)'(1) << exp_sat);
        reb_base_next = (base_sum > {1'b0, BASE_CAP}) ? BASE_CAP : base_sum[BASE_W-1:0];
        reb_exp_next  = exp_sat;
        reb_idx_next  = reb_idx_reg + LVL_W'(1);

        wr_en         = (state_reg == ST_CLEAR);
        wr_data.base  = reb_base_reg;
        wr_data.width = fld_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            reb_idx_reg  <= '0;
            reb_exp_reg  <= '0;
            reb_base_reg <= '0;
        end else if (state_reg == ST_CLEAR) begin
            reb_idx_reg  <= reb_idx_next;
            reb_exp_reg  <= reb_exp_next;
            reb_base_reg <= reb_base_next;
        end
    end

    // ---------------- level table memory ----------------
    always_ff @(posedge aclk) begin
        if (wr_en)
            lvl_mem[reb_idx_reg] <= wr_data;
        rd_data_reg <= lvl_mem[rd_addr];
    end

    // ---------------- item datapath ----------------
    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign out_free   = !m_valid_reg || m_tready;
    assign hit        = {1'b0, val_reg} >= rd_data_reg.base;
    assign probe_more = ({1'b0, probe_reg} + LVCNT_W'(1)) < levels;

    assign cur_w      = rd_data_reg.width;
    assign chunk_mask = VALUE_BITS'(~({(VALUE_BITS+1){1'b1}} << cur_w));
    assign chunk_val  = rem_reg & chunk_mask;
    assign rem_shift  = rem_reg >> cur_w;
    assign fin        = (lvl_reg == top_reg);
    assign in_bitmap  = ({1'b0, lvl_reg} + LVCNT_W'(1)) < levels;
    assign ovf        = fin && (rem_shift != '0);

    always_comb begin
        state_next   = state_reg;
        val_next     = val_reg;
        rem_next     = rem_reg;
        probe_next   = probe_reg;
        top_next     = top_reg;
        lvl_next     = lvl_reg;
        rd_addr      = '0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                if (reb_idx_reg == LVL_W'(MAX_LEVELS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    val_next   = s_tdata[VALUE_BITS-1:0];
                    rem_next   = s_tdata[VALUE_BITS-1:0];
                    top_next   = '0;
                    lvl_next   = '0;
                    probe_next = LVL_W'(1);
                    if (levels == LVCNT_W'(1)) begin
                        rd_addr    = '0;
                        state_next = ST_EMIT;
                    end else begin
                        rd_addr    = LVL_W'(1);
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    top_next = probe_reg;
                    rem_next = VALUE_BITS'({1'b0, val_reg} - rd_data_reg.base);
                end
                if (hit && probe_more) begin
                    probe_next = probe_reg + LVL_W'(1);
                    rd_addr    = probe_reg + LVL_W'(1);
                end else begin
                    rd_addr    = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({cur_w, chunk_val, lvl_reg});
                    m_user_next  = {ovf, in_bitmap, fin};
                    m_last_next  = fin;
                    rem_next     = rem_shift;
                    lvl_next     = lvl_reg + LVL_W'(1);
                    rd_addr      = lvl_reg + LVL_W'(1);
                    if (fin)
                        state_next = ST_IDLE;
                end else begin
                    rd_addr = lvl_reg;
                end
            end
            default: state_next = ST_CLEAR;
        endcase

        if (cfg_wr_en)
            state_next = ST_CLEAR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        rem_reg    <= rem_next;
        probe_reg  <= probe_next;
        top_reg    <= top_next;
        lvl_reg    <= lvl_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    a_emit_within_top: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> lvl_reg <= top_reg)
        else $error("chunk level beyond top level");

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> {1'b0, probe_reg} < levels)
        else $error("table probe past levels in use");

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input accepted during table rebuild");

    a_overflow_on_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg[2] |-> m_user_reg[0] && m_last_reg)
        else $error("overflow flagged on a non-final chunk");

endmodule

`default_nettype wire

// File: bench/dacs_chunk_encoder_tb.sv
// Self-checking bench for dacs_chunk_encoder: streams values, predicts every chunk.
// Needs dacs_pkg for port widths, register indexes and reset values.
`default_nettype none

module dacs_chunk_encoder_tb;
    import dacs_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 70;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        bit [4:0]  level;
        bit [31:0] chunk;
        bit [5:0]  width;
        bit        stop;
        bit        in_bitmap;
        bit        overflow;
        bit        last;
    } chunk_rec_t;

    class chunk_scoreboard;
        bit [47:0] width_list;
        bit [3:0]  list_count;
        bit [5:0]  level_count;
        bit [32:0] base_tab[32];
        bit [5:0]  width_tab[32];
        chunk_rec_t chunk_q[$];
        int errors;

        function new();
            width_list  = RESET_WIDTHS;
            list_count  = RESET_LIST_COUNT;
            level_count = RESET_LEVELS;
            errors      = 0;
            rebuild();
        endfunction

        function void rebuild();
            int n;
            int e;
            int w;
            longint unsigned acc;
            n   = int'(list_count);
            e   = 0;
            acc = 0;
            if (n == 0) n = 1;
            if (n > 8) n = 8;
            for (int i = 0; i < 32; i++) begin
                w = int'(width_list[6 * ((i < n) ? i : n - 1) +: 6]);
                if (w == 0) w = 1;
                if (w > 32) w = 32;
                width_tab[i] = 6'(w);
                base_tab[i]  = 33'(acc);
                e += w;
                if (e > 32) e = 32;
                acc += 64'd1 << e;
                if (acc > 64'h1_0000_0000) acc = 64'h1_0000_0000;
            end
        endfunction

        function void write_reg(bit [CFG_ADDR_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WIDTH_LIST:  width_list  = data;
                CFG_LIST_COUNT:  list_count  = data[3:0];
                CFG_LEVEL_COUNT: level_count = data[5:0];
                default: return;
            endcase
            rebuild();
        endfunction

        function int levels_in_use();
            int n;
            n = int'(level_count);
            if (n == 0) n = 1;
            if (n > 32) n = 32;
            return n;
        endfunction

        function int pending();
            return chunk_q.size();
        endfunction

        function void note_value(bit [31:0] value);
            int levels;
            int top;
            int w;
            longint unsigned rem;
            chunk_rec_t rec;
            levels = levels_in_use();
            top    = 0;
            for (int i = 0; i < levels; i++)
                if ({1'b0, value} >= base_tab[i]) top = i;
            rem = {32'd0, value} - {31'd0, base_tab[top]};
            for (int k = 0; k <= top; k++) begin
                w             = int'(width_tab[k]);
                rec.level     = 5'(k);
                rec.chunk     = 32'(rem & ((64'd1 << w) - 64'd1));
                rec.width     = 6'(w);
                rec.stop      = (k == top);
                rec.in_bitmap = (k + 1 < levels);
                rec.overflow  = (k == top) && ((rem >> w) != 0);
                rec.last      = (k == top);
                chunk_q.push_back(rec);
                rem = rem >> w;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(bit [M_TDATA_W-1:0] tdata, bit [M_TUSER_W-1:0] tuser, bit tlast);
            chunk_rec_t exp_rec;
            if (chunk_q.size() == 0) begin
                report($sformatf("unexpected chunk tdata=%h tuser=%b", tdata, tuser));
                return;
            end
            exp_rec = chunk_q.pop_front();
            if (tdata[4:0] !== exp_rec.level)
                report($sformatf("level %0d, want %0d", tdata[4:0], exp_rec.level));
            if (tdata[36:5] !== exp_rec.chunk)
                report($sformatf("chunk %h, want %h (level %0d)", tdata[36:5], exp_rec.chunk,
                                 exp_rec.level));
            if (tdata[42:37] !== exp_rec.width)
                report($sformatf("chunk_width %0d, want %0d (level %0d)", tdata[42:37],
                                 exp_rec.width, exp_rec.level));
            if (tuser[0] !== exp_rec.stop)
                report($sformatf("stop %b, want %b (level %0d)", tuser[0], exp_rec.stop,
                                 exp_rec.level));
            if (tuser[1] !== exp_rec.in_bitmap)
                report($sformatf("in_bitmap %b, want %b (level %0d)", tuser[1],
                                 exp_rec.in_bitmap, exp_rec.level));
            if (tuser[2] !== exp_rec.overflow)
                report($sformatf("overflow %b, want %b (level %0d)", tuser[2],
                                 exp_rec.overflow, exp_rec.level));
            if (tlast !== exp_rec.last)
                report($sformatf("tlast %b, want %b (level %0d)", tlast, exp_rec.last,
                                 exp_rec.level));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    chunk_scoreboard sb = new();
    bit sender_quiet   = 1'b0;
    bit receiver_quiet = 1'b0;
    int hold_cycles    = 0;

    dacs_chunk_encoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #7200000;
        $display("dacs_chunk_encoder_tb: FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_value(s_tdata[31:0]);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = receiver_quiet ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 19) == 0) receiver_quiet = !receiver_quiet;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_value(input bit [31:0] value);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 19) == 0) sender_quiet = !sender_quiet;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic bit [31:0] pick_value();
        int k;
        bit [32:0] b;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: begin
                k = $urandom_range(0, sb.levels_in_use() - 1);
                b = sb.base_tab[k];
                if (b[32]) return $urandom;
                return b[31:0] + $urandom_range(0, 3) - 1;
            end
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_value(pick_value());
        drain();
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] widths, input int list_n,
                             input int levels);
        write_reg(CFG_WIDTH_LIST, widths);
        write_reg(CFG_LIST_COUNT, CFG_DATA_W'(list_n));
        write_reg(CFG_LEVEL_COUNT, CFG_DATA_W'(levels));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset widths: four bits per level, eight levels
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd15);
        send_value(32'd16);
        send_value(32'd271);
        send_value(32'd272);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
        hold_cycles = LONG_HOLD;
        send_random(48);

        // one-bit chunks on all 32 levels
        write_all(48'h041_041_041_041, 8, 32);
        send_value(32'hFFFF_FFFF);
        send_value(32'hFFFF_FFFE);
        send_value(32'hFFFF_FFFD);
        send_random(40);

        // zero width field, zero list count, zero level count
        write_all(CFG_DATA_W'({$urandom, $urandom}) & ~48'h3F, 0, 0);
        write_reg(CFG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'hFFFF_FFFF);
        send_random(40);

        // oversized widths, list count and level count saturate
        write_all(48'hFFFF_FFFF_FFFF, 15, 63);
        send_value(32'hFFFF_FFFF);
        send_random(40);

        // short list, last width repeats
        write_all({30'd0, 6'd2, 6'd7, 6'd3}, 3, 20);
        send_random(48);

        repeat (3) begin
            write_all(CFG_DATA_W'({$urandom, $urandom}), $urandom_range(0, 15),
                      $urandom_range(0, 63));
            if ($urandom_range(0, 1) == 1) hold_cycles = LONG_HOLD;
            send_random(50);
        end

        if (sb.errors == 0) begin
            $display("dacs_chunk_encoder_tb: PASS");
        end else begin
            $display("dacs_chunk_encoder_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hdl/dacs_pkg.sv
hdl/dacs_chunk_encoder.sv
bench/dacs_chunk_encoder_tb.sv
